// ===== design/tcsd_pkg.sv =====
// Shared types, constants and line formatting functions for the tick count
// display formatter. Used by every module of the block; depends on nothing.
`default_nettype none

package tcsd_pkg;

  localparam int TICK_WIDTH = 24;
  localparam int PAD_SPACES = 7;
  localparam int LINE_MAX   = 15;

  localparam int REM_W      = 20;
  localparam int CNT_W      = $clog2(TICK_WIDTH + 1);
  localparam int BCD_DIGITS = 6;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int POS_W      = $clog2(LINE_MAX);

  localparam logic [REM_W:0] DIV_MIN_SEC = (REM_W + 1)'(6000);
  localparam logic [REM_W:0] DIV_DEC     = (REM_W + 1)'(1000000);

  localparam logic [1:0] MODE_MIN_SEC = 2'd1;
  localparam logic [1:0] MODE_FIXED   = 2'd2;
  localparam logic [1:0] MODE_PLAIN   = 2'd3;

  localparam logic [7:0] CHAR_KEY_1   = 8'h31;
  localparam logic [7:0] CHAR_KEY_2   = 8'h32;
  localparam logic [7:0] CHAR_KEY_3   = 8'h33;
  localparam logic [7:0] CHAR_QUIT    = 8'h71;
  localparam logic [7:0] CHAR_COLON   = 8'h3a;
  localparam logic [7:0] CHAR_POINT   = 8'h2e;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_CR      = 8'h0d;
  localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;

  typedef struct packed {
    logic                  rx_valid;
    logic [7:0]            rx_char;
    logic [TICK_WIDTH-1:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic long_div;
  } div_cmd_t;

  typedef struct packed {
    logic q_vld;
    logic r_vld;
    logic bit_out;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic bit_in;
  } bcd_cmd_t;

  typedef struct packed {
    logic       start;
    logic [1:0] mode;
  } emit_cmd_t;

  typedef struct packed {
    logic busy;
  } emit_stat_t;

  function automatic logic [POS_W-1:0] body_len(input logic [1:0] mode);
    case (mode)
      MODE_FIXED: return POS_W'(7);
      MODE_PLAIN: return POS_W'(6);
      default:    return POS_W'(5);
    endcase
  endfunction

  // Position of the closing carriage return; the padding is cut short so
  // that a line never exceeds the maximum length.
  function automatic logic [POS_W-1:0] line_last(input logic [1:0] mode);
    int b;
    int p;
    b = int'(body_len(mode));
    p = PAD_SPACES;
    if (p > LINE_MAX - 1 - b) begin
      p = LINE_MAX - 1 - b;
    end
    return POS_W'(b + p);
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return {CHAR_DIGIT_HI, d};
  endfunction

  function automatic out_item_t line_char(input logic [1:0]       mode,
                                          input logic [POS_W-1:0] pos,
                                          input logic [BCD_W-1:0] qd,
                                          input logic [BCD_W-1:0] rd);
    out_item_t item;
    item.out_char = CHAR_SPACE;
    item.last     = 1'b0;
    if (pos == line_last(mode)) begin
      item.out_char = CHAR_CR;
      item.last     = 1'b1;
    end else if (pos < body_len(mode)) begin
      case (mode)
        MODE_FIXED: begin
          case (pos)
            POS_W'(0): item.out_char = digit_char(rd[23:20]);
            POS_W'(1): item.out_char = digit_char(rd[19:16]);
            POS_W'(2): item.out_char = digit_char(rd[15:12]);
            POS_W'(3): item.out_char = digit_char(rd[11:8]);
            POS_W'(4): item.out_char = CHAR_POINT;
            POS_W'(5): item.out_char = digit_char(rd[7:4]);
            default:   item.out_char = digit_char(rd[3:0]);
          endcase
        end
        MODE_PLAIN: begin
          case (pos)
            POS_W'(0): item.out_char = digit_char(rd[23:20]);
            POS_W'(1): item.out_char = digit_char(rd[19:16]);
            POS_W'(2): item.out_char = digit_char(rd[15:12]);
            POS_W'(3): item.out_char = digit_char(rd[11:8]);
            POS_W'(4): item.out_char = digit_char(rd[7:4]);
            default:   item.out_char = digit_char(rd[3:0]);
          endcase
        end
        default: begin
          case (pos)
            POS_W'(0): item.out_char = digit_char(qd[7:4]);
            POS_W'(1): item.out_char = digit_char(qd[3:0]);
            POS_W'(2): item.out_char = CHAR_COLON;
            POS_W'(3): item.out_char = digit_char(rd[15:12]);
            default:   item.out_char = digit_char(rd[11:8]);
          endcase
        end
      endcase
    end
    return item;
  endfunction

endpackage

`default_nettype wire

// ===== design/tcsd_div.sv =====
// Bit-serial restoring divider of the tick count by 6000 or 1000000.
// Emits quotient bits MSB first, then shifts the remainder out. Uses tcsd_pkg.
`default_nettype none

module tcsd_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tcsd_pkg::div_cmd_t             cmd,
  input  wire logic [tcsd_pkg::TICK_WIDTH-1:0] dividend,
  output tcsd_pkg::div_stat_t                 stat
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_DIV,
    D_OUT
  } div_state_t;

  div_state_t                        state_r;
  logic [tcsd_pkg::CNT_W-1:0]        cnt_r;
  logic [tcsd_pkg::TICK_WIDTH-1:0]   dvd_r;
  logic [tcsd_pkg::REM_W-1:0]        rem_r;
  logic                              long_r;

  logic [tcsd_pkg::REM_W:0]          trial;
  logic [tcsd_pkg::REM_W:0]          divisor;
  logic [tcsd_pkg::REM_W:0]          diff;
  logic                              ge;
  logic [tcsd_pkg::REM_W-1:0]        rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[tcsd_pkg::TICK_WIDTH-1]};
    divisor = long_r ? tcsd_pkg::DIV_DEC : tcsd_pkg::DIV_MIN_SEC;
    diff    = trial - divisor;
    ge      = (trial >= divisor);
    rem_nxt = ge ? diff[tcsd_pkg::REM_W-1:0] : trial[tcsd_pkg::REM_W-1:0];

    stat.q_vld   = (state_r == D_DIV);
    stat.r_vld   = (state_r == D_OUT);
    stat.bit_out = (state_r == D_DIV) ? ge : rem_r[tcsd_pkg::REM_W-1];
    stat.done    = (state_r == D_OUT) && (cnt_r == tcsd_pkg::CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        D_IDLE: begin
          if (cmd.start) begin
            dvd_r   <= dividend;
            rem_r   <= '0;
            long_r  <= cmd.long_div;
            cnt_r   <= tcsd_pkg::CNT_W'(tcsd_pkg::TICK_WIDTH);
            state_r <= D_DIV;
          end
        end
        D_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[tcsd_pkg::TICK_WIDTH-2:0], 1'b0};
          if (cnt_r == tcsd_pkg::CNT_W'(1)) begin
            cnt_r   <= tcsd_pkg::CNT_W'(tcsd_pkg::REM_W);
            state_r <= D_OUT;
          end else begin
            cnt_r <= cnt_r - tcsd_pkg::CNT_W'(1);
          end
        end
        D_OUT: begin
          rem_r <= {rem_r[tcsd_pkg::REM_W-2:0], 1'b0};
          cnt_r <= cnt_r - tcsd_pkg::CNT_W'(1);
          if (cnt_r == tcsd_pkg::CNT_W'(1)) begin
            state_r <= D_IDLE;
          end
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tcsd_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add three), MSB first.
// Digits beyond the top one are dropped, so it keeps the value mod 10^6.
`default_nettype none

module tcsd_bcd (
  input  wire logic                      clk,
  input  wire tcsd_pkg::bcd_cmd_t        cmd,
  output logic [tcsd_pkg::BCD_W-1:0]     digits
);

  logic [tcsd_pkg::BCD_W-1:0] digits_r;
  logic [tcsd_pkg::BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < tcsd_pkg::BCD_DIGITS; i++) begin
      if (digits_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digits_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = digits_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      digits_r <= '0;
    end else if (cmd.shift) begin
      digits_r <= {adj[tcsd_pkg::BCD_W-2:0], cmd.bit_in};
    end
  end

  assign digits = digits_r;

endmodule

`default_nettype wire

// ===== design/tcsd_emit.sv =====
// Line sequencer: walks the character positions of one display line and
// feeds them into the output register. Uses tcsd_pkg.
`default_nettype none

module tcsd_emit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tcsd_pkg::emit_cmd_t        cmd,
  input  wire logic [tcsd_pkg::BCD_W-1:0] q_digits,
  input  wire logic [tcsd_pkg::BCD_W-1:0] r_digits,
  output tcsd_pkg::emit_stat_t            stat,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output tcsd_pkg::out_item_t             out_data
);

  logic                          active_r;
  logic [tcsd_pkg::POS_W-1:0]    pos_r;
  logic [1:0]                    mode_r;
  logic                          out_valid_r;
  tcsd_pkg::out_item_t           out_data_r;

  logic                          push;
  tcsd_pkg::out_item_t           item;

  always_comb begin
    push      = active_r && (!out_valid_r || !out_stall);
    item      = tcsd_pkg::line_char(mode_r, pos_r, q_digits, r_digits);
    stat.busy = active_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= '0;
      mode_r      <= tcsd_pkg::MODE_MIN_SEC;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        active_r <= 1'b1;
        pos_r    <= '0;
        mode_r   <= cmd.mode;
      end
      if (push) begin
        out_data_r  <= item;
        out_valid_r <= 1'b1;
        pos_r       <= pos_r + tcsd_pkg::POS_W'(1);
        if (pos_r == tcsd_pkg::line_last(mode_r)) begin
          active_r <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/tick_count_serial_display_formatter_top.sv =====
// Tick count display formatter: one poll in, one ASCII display line out.
// The first character of a line follows the divider's 24 bit-serial divide
// steps and 20 remainder shift-out steps, then one character per cycle while
// out_stall is low; no new poll is taken until the line is out. A quit poll,
// or any poll once halted, gives no line. Uses tcsd_pkg and all tcsd units.
// Synchronous active-low reset selects minutes and seconds and clears halt.
`default_nettype none

module tick_count_serial_display_formatter_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tcsd_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tcsd_pkg::out_item_t       out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } top_state_t;

  top_state_t              state_r;
  logic [1:0]              mode_r;
  logic                    halted_r;

  logic                    accept;
  logic                    is_quit;
  logic                    go;
  logic [1:0]              mode_nxt;

  tcsd_pkg::div_cmd_t      div_cmd;
  tcsd_pkg::div_stat_t     div_stat;
  tcsd_pkg::bcd_cmd_t      q_cmd;
  tcsd_pkg::bcd_cmd_t      r_cmd;
  tcsd_pkg::emit_cmd_t     emit_cmd;
  tcsd_pkg::emit_stat_t    emit_stat;
  logic [tcsd_pkg::BCD_W-1:0] q_digits;
  logic [tcsd_pkg::BCD_W-1:0] r_digits;

  always_comb begin
    in_stall = (state_r != S_IDLE);
    accept   = in_valid && !in_stall;
    is_quit  = in_data.rx_valid && (in_data.rx_char == tcsd_pkg::CHAR_QUIT);

    mode_nxt = mode_r;
    if (in_data.rx_valid) begin
      unique case (in_data.rx_char)
        tcsd_pkg::CHAR_KEY_1: mode_nxt = tcsd_pkg::MODE_MIN_SEC;
        tcsd_pkg::CHAR_KEY_2: mode_nxt = tcsd_pkg::MODE_FIXED;
        tcsd_pkg::CHAR_KEY_3: mode_nxt = tcsd_pkg::MODE_PLAIN;
        default:              mode_nxt = mode_r;
      endcase
    end

    go = accept && !halted_r && !is_quit;

    div_cmd.start    = go;
    div_cmd.long_div = (mode_nxt == tcsd_pkg::MODE_FIXED) ||
                       (mode_nxt == tcsd_pkg::MODE_PLAIN);

    q_cmd.clear  = go;
    q_cmd.shift  = div_stat.q_vld;
    q_cmd.bit_in = div_stat.bit_out;
    r_cmd.clear  = go;
    r_cmd.shift  = div_stat.r_vld;
    r_cmd.bit_in = div_stat.bit_out;

    emit_cmd.start = div_stat.done;
    emit_cmd.mode  = mode_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= tcsd_pkg::MODE_MIN_SEC;
      halted_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept && !halted_r) begin
            mode_r <= mode_nxt;
            if (is_quit) begin
              halted_r <= 1'b1;
            end
          end
          if (go) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!emit_stat.busy) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  tcsd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (in_data.tick_count),
    .stat     (div_stat)
  );

  tcsd_bcd u_bcd_quo (
    .clk    (clk),
    .cmd    (q_cmd),
    .digits (q_digits)
  );

  tcsd_bcd u_bcd_rem (
    .clk    (clk),
    .cmd    (r_cmd),
    .digits (r_digits)
  );

  tcsd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (emit_cmd),
    .q_digits  (q_digits),
    .r_digits  (r_digits),
    .stat      (emit_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
